// ----- rtl/core/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, codes and types of the quintic trajectory evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

  // Field widths, Q16.16 values and Q8.16 times.
  localparam int VAL_W     = 32;
  localparam int VAL_FRAC  = 16;
  localparam int TIME_W    = 24;
  localparam int TIME_FRAC = 16;

  // Coefficients are Q16.32, 48 bits signed.
  localparam int COEF_W    = 48;
  localparam int COEF_FRAC = 2 * VAL_FRAC;

  // Configuration port.
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam logic [TIME_W-1:0] DUR_RESET = TIME_W'(1 << TIME_FRAC);

  localparam logic [REG_IDX_W-1:0] REG_START_POS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_VEL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_ACC = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_POS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_VEL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_ACC   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DURATION  = 3'd6;

  // Solver arithmetic.
  localparam int NX_W      = 38;   // boundary terms n2, n3
  localparam int N1H_W     = 40;   // n1 * h
  localparam int PRD_W     = 63;   // n * D
  localparam int PRT_W     = 56;   // limb * D
  localparam int N_W       = 90;   // full numerator at scale 2^48
  localparam int PRESCALE  = VAL_FRAC + 2 * TIME_FRAC - COEF_FRAC + 1;
  localparam int CLAMP_BIT = 100;
  localparam int MAG_W     = CLAMP_BIT + 1;
  localparam int DIV_W     = MAG_W + TIME_FRAC;

  // Evaluation datapath.
  localparam int DERIV_W   = 56;
  localparam int ACC_W     = 96;
  localparam int NUM_LANES = 4;
  localparam int NUM_CELLS = 5;

  // Status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  typedef enum logic [2:0] {
    SOLVE_IDLE,
    SOLVE_CHECK,
    SOLVE_MUL1,
    SOLVE_MUL2,
    SOLVE_SUM,
    SOLVE_DIV,
    SOLVE_STORE
  } solve_state_e;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DERIV_W-1:0] deriv_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Control that travels with a word along the cell row.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] t;
  } cell_ctl_t;

  // Small integer factor of a derivative coefficient.
  function automatic deriv_t scale(deriv_t x, int f);
    return x * deriv_t'(f);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qte_div.sv -----
// ----------------------------------------------------------------------------
// qte_div
// Restoring divider, one quotient bit per cycle, used by the solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [qte_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [qte_pkg::TIME_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [qte_pkg::DIV_W-1:0]        quotient_o
);

  localparam int CNT_W = $clog2(qte_pkg::DIV_W + 1);

  logic [qte_pkg::DIV_W-1:0]  x_q, x_d;
  logic [qte_pkg::TIME_W-1:0] rem_q;
  logic [qte_pkg::TIME_W:0]   rem_sh, rem_d;
  logic [CNT_W-1:0]           cnt_q;
  logic                       done_q;
  logic                       ge;

  // One shift and trial subtract.
  always_comb begin
    rem_sh = {rem_q, x_q[qte_pkg::DIV_W-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    rem_d  = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
    x_d    = {x_q[qte_pkg::DIV_W-2:0], ge};
  end

  // Iteration counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(qte_pkg::DIV_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      x_q   <= x_d;
      rem_q <= rem_d[qte_pkg::TIME_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = x_q;

endmodule

`default_nettype wire

// ----- rtl/core/qte_solver.sv -----
// ----------------------------------------------------------------------------
// qte_solver
// Boundary registers and the sequential solve of the quintic coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_solver (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qte_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [qte_pkg::CFG_W-1:0]      cfg_data_i,
  output qte_pkg::coef_t                      coef_o [6],
  output logic                                failed_o,
  output logic                                busy_o
);

  localparam int NX_W  = qte_pkg::NX_W;
  localparam int N1H_W = qte_pkg::N1H_W;
  localparam int PRD_W = qte_pkg::PRD_W;
  localparam int PRT_W = qte_pkg::PRT_W;
  localparam int N_W   = qte_pkg::N_W;
  localparam int MAG_W = qte_pkg::MAG_W;
  localparam int VW    = qte_pkg::VAL_W;
  localparam int CW    = qte_pkg::COEF_W;

  qte_pkg::solve_state_e state_q, state_d;

  logic signed [VW-1:0] p0_q, v0_q, a0_q, p1_q, v1_q, a1_q;
  logic [qte_pkg::TIME_W-1:0] dur_q;

  logic [1:0]              k_q;
  logic [2:0]              nd_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        m_q;
  logic signed [N1H_W-1:0] n1h_q;
  logic signed [PRD_W-1:0] t2p_q, t3p_q;
  logic [PRT_W-1:0]        t3lo_q;
  logic signed [PRT_W-1:0] t3hi_q;
  qte_pkg::coef_t          a_q [3];
  logic                    failed_q;
  logic                    div_start_q, div_start_d;

  logic                    cfg_hit;
  logic signed [N1H_W-1:0] hx, n1h;
  logic signed [NX_W-1:0]  v0x, v1x, a0x, a1x, n2, n3;
  logic signed [PRD_W-1:0] dur_s;
  logic signed [N_W-1:0]   nsum;
  logic [N_W-1:0]          nmag;
  logic                    div_done;
  logic [qte_pkg::DIV_W-1:0] quo;
  logic                    quo_over, last_div, over48;
  logic [MAG_W-1:0]        quo_clamp, cmax;
  logic [CW-1:0]           mag48;

  assign cfg_hit = cfg_we_i && (cfg_idx_i < qte_pkg::REG_IDX_W'(qte_pkg::NUM_REGS));

  // Boundary registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q  <= '0;
      v0_q  <= '0;
      a0_q  <= '0;
      p1_q  <= '0;
      v1_q  <= '0;
      a1_q  <= '0;
      dur_q <= qte_pkg::DUR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qte_pkg::REG_START_POS: p0_q  <= cfg_data_i;
        qte_pkg::REG_START_VEL: v0_q  <= cfg_data_i;
        qte_pkg::REG_START_ACC: a0_q  <= cfg_data_i;
        qte_pkg::REG_END_POS:   p1_q  <= cfg_data_i;
        qte_pkg::REG_END_VEL:   v1_q  <= cfg_data_i;
        qte_pkg::REG_END_ACC:   a1_q  <= cfg_data_i;
        qte_pkg::REG_DURATION:  dur_q <= cfg_data_i[qte_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Boundary terms of the coefficient being solved.
  always_comb begin
    hx  = N1H_W'(p1_q) - N1H_W'(p0_q);
    v0x = NX_W'(v0_q);
    v1x = NX_W'(v1_q);
    a0x = NX_W'(a0_q);
    a1x = NX_W'(a1_q);
    unique case (k_q)
      2'd0: begin
        n1h = hx * 20;
        n2  = -((v1x * 8) + (v0x * 12));
        n3  = a1x - (a0x * 3);
      end
      2'd1: begin
        n1h = -(hx * 30);
        n2  = (v1x * 14) + (v0x * 16);
        n3  = (a0x * 3) - (a1x * 2);
      end
      default: begin
        n1h = hx * 12;
        n2  = -((v1x + v0x) * 6);
        n3  = a1x - a0x;
      end
    endcase
  end

  assign dur_s = PRD_W'({1'b0, dur_q});

  // Numerator at scale 2^48 and its magnitude.
  always_comb begin
    nsum = (N_W'(n1h_q) <<< 32) + (N_W'(t2p_q) <<< qte_pkg::TIME_FRAC)
         + (N_W'(t3hi_q) <<< 32) + N_W'(t3lo_q);
    nmag = nsum[N_W-1] ? N_W'(-nsum) : N_W'(nsum);
  end

  qte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ({m_q, {qte_pkg::TIME_FRAC{1'b0}}}),
    .divisor_i  (dur_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Quotient clamp and final 48-bit saturation.
  always_comb begin
    quo_over  = (|quo[qte_pkg::DIV_W-1:MAG_W])
             || (quo[MAG_W-1] && (|quo[MAG_W-2:0]));
    quo_clamp = quo_over ? {1'b1, {(MAG_W-1){1'b0}}} : quo[MAG_W-1:0];
    last_div  = (nd_q == ({1'b0, k_q} + 3'd2));
    cmax      = (MAG_W'(1) << (CW - 1)) - MAG_W'(!neg_q);
    over48    = m_q > cmax;
    mag48     = over48 ? cmax[CW-1:0] : m_q[CW-1:0];
  end

  // Solve sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qte_pkg::SOLVE_IDLE;
      div_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    unique case (state_q)
      qte_pkg::SOLVE_IDLE:  if (cfg_hit) state_d = qte_pkg::SOLVE_CHECK;
      qte_pkg::SOLVE_CHECK: begin
        state_d = (dur_q == '0) ? qte_pkg::SOLVE_IDLE : qte_pkg::SOLVE_MUL1;
      end
      qte_pkg::SOLVE_MUL1:  state_d = qte_pkg::SOLVE_MUL2;
      qte_pkg::SOLVE_MUL2:  state_d = qte_pkg::SOLVE_SUM;
      qte_pkg::SOLVE_SUM: begin
        state_d     = qte_pkg::SOLVE_DIV;
        div_start_d = 1'b1;
      end
      qte_pkg::SOLVE_DIV: begin
        if (div_done) begin
          if (last_div) state_d = qte_pkg::SOLVE_STORE;
          else          div_start_d = 1'b1;
        end
      end
      qte_pkg::SOLVE_STORE: begin
        state_d = (k_q == 2'd2) ? qte_pkg::SOLVE_IDLE : qte_pkg::SOLVE_MUL1;
      end
      default: state_d = qte_pkg::SOLVE_IDLE;
    endcase
  end

  // Sequencer control registers and solved coefficients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      nd_q     <= '0;
      failed_q <= 1'b0;
      a_q[0]   <= '0;
      a_q[1]   <= '0;
      a_q[2]   <= '0;
    end else begin
      unique case (state_q)
        qte_pkg::SOLVE_CHECK: begin
          k_q      <= '0;
          failed_q <= (dur_q == '0);
          if (dur_q == '0) begin
            a_q[0] <= '0;
            a_q[1] <= '0;
            a_q[2] <= '0;
          end
        end
        qte_pkg::SOLVE_SUM: nd_q <= '0;
        qte_pkg::SOLVE_DIV: if (div_done) nd_q <= nd_q + 3'd1;
        qte_pkg::SOLVE_STORE: begin
          a_q[k_q] <= neg_q ? -$signed(mag48) : $signed(mag48);
          k_q      <= k_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers of the solve.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      qte_pkg::SOLVE_MUL1: begin
        n1h_q <= n1h;
        t2p_q <= PRD_W'(n2) * dur_s;
        t3p_q <= PRD_W'(n3) * dur_s;
      end
      qte_pkg::SOLVE_MUL2: begin
        t3lo_q <= PRT_W'(t3p_q[31:0]) * PRT_W'(dur_q);
        t3hi_q <= PRT_W'($signed(t3p_q[PRD_W-1:32])) * PRT_W'({1'b0, dur_q});
      end
      qte_pkg::SOLVE_SUM: begin
        neg_q <= nsum[N_W-1];
        m_q   <= MAG_W'(nmag >> qte_pkg::PRESCALE);
      end
      qte_pkg::SOLVE_DIV: if (div_done) m_q <= quo_clamp;
      default: ;
    endcase
  end

  // The first three coefficients follow the start state directly.
  assign coef_o[0] = {p0_q, {(CW - VW){1'b0}}};
  assign coef_o[1] = {v0_q, {(CW - VW){1'b0}}};
  assign coef_o[2] = {a0_q[VW-1], a0_q, {(CW - VW - 1){1'b0}}};
  assign coef_o[3] = a_q[0];
  assign coef_o[4] = a_q[1];
  assign coef_o[5] = a_q[2];

  assign failed_o = failed_q;
  assign busy_o   = (state_q != qte_pkg::SOLVE_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/qte_cell.sv -----
// ----------------------------------------------------------------------------
// qte_cell
// One Horner step, acc * t / 2^16 + c, over two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire qte_pkg::cell_ctl_t ctl_i,
  input  wire qte_pkg::acc_t      acc_i,
  input  wire qte_pkg::deriv_t    coef_i,
  output qte_pkg::cell_ctl_t      ctl_o,
  output qte_pkg::acc_t           acc_o
);

  localparam int AW   = qte_pkg::ACC_W;
  localparam int PW   = 32 + qte_pkg::TIME_W;
  localparam int SUMW = AW + qte_pkg::TIME_W + 1;

  qte_pkg::cell_ctl_t   ctl_a_q, ctl_b_q;
  logic [PW-1:0]        plo_q, pmid_q;
  logic signed [PW:0]   phi_q;
  qte_pkg::acc_t        acc_b_q;
  logic signed [SUMW-1:0] psum;
  logic signed [SUMW-1:0] pshift;

  // Control follows the data through both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  // Stage A: three limb products of the accumulator with the time.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= PW'(acc_i[31:0]) * PW'(ctl_i.t);
      pmid_q <= PW'(acc_i[63:32]) * PW'(ctl_i.t);
      phi_q  <= (PW + 1)'($signed(acc_i[AW-1:64])) * (PW + 1)'({1'b0, ctl_i.t});
    end
  end

  // Stage B: recombine, floor by the time scale, add the coefficient.
  always_comb begin
    psum   = (SUMW'(phi_q) <<< 64) + (SUMW'(pmid_q) << 32) + SUMW'(plo_q);
    pshift = psum >>> qte_pkg::TIME_FRAC;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_b_q <= AW'(pshift) + AW'(coef_i);
    end
  end

  assign ctl_o = ctl_b_q;
  assign acc_o = acc_b_q;

endmodule

`default_nettype wire

// ----- rtl/core/quintic_trajectory_evaluator.sv -----
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator
// Solves a quintic from boundary states and evaluates p, p', p'', p'''.
// ----------------------------------------------------------------------------
//  Channel  Signals                                  Dir  Word
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i          in   one register write
//  in       in_valid_i, in_ready_o, sample_time_i    in   one Q8.16 sample time
//  out      out_valid_o, out_ready_i, position_o,    out  p, v, a, jerk, status
//           velocity_o, acceleration_o, jerk_o, status_o
//
//  One word per cycle while no write or solve is under way and the output is
//  not stalled; a word passes five Horner cells of two stages each, per lane,
//  then the output register. A write to a defined register while idle starts
//  a solve in the shared bit-serial divider, in_ready_o low meanwhile. Reset needs no solve.
//  A stalled output freezes the whole cell row; no word is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quintic_trajectory_evaluator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qte_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [qte_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [qte_pkg::TIME_W-1:0]     sample_time_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [qte_pkg::VAL_W-1:0]    position_o,
  output logic signed [qte_pkg::VAL_W-1:0]    velocity_o,
  output logic signed [qte_pkg::VAL_W-1:0]    acceleration_o,
  output logic signed [qte_pkg::VAL_W-1:0]    jerk_o,
  output logic [1:0]                          status_o
);

  localparam int NL = qte_pkg::NUM_LANES;
  localparam int NC = qte_pkg::NUM_CELLS;
  localparam int AW = qte_pkg::ACC_W;
  localparam int VW = qte_pkg::VAL_W;

  qte_pkg::coef_t     coef [6];
  qte_pkg::deriv_t    ax [6];
  qte_pkg::deriv_t    lst [NL][6];
  qte_pkg::cell_ctl_t ctl [NL][NC+1];
  qte_pkg::acc_t      acc [NL][NC+1];
  logic               failed, busy, adv, in_fire, last_valid;
  logic [NL-1:0]      lane_valid, lane_sat;
  logic signed [VW-1:0] lane_val [NL];
  logic               out_valid_q;
  logic signed [VW-1:0] val_q [NL];
  logic [1:0]         status_q;

  qte_solver u_solver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef),
    .failed_o   (failed),
    .busy_o     (busy)
  );

  // Coefficient lists of the four polynomials, highest degree padded with zero.
  always_comb begin
    for (int i = 0; i < 6; i++) ax[i] = qte_pkg::DERIV_W'(coef[i]);
    for (int l = 0; l < NL; l++) begin
      for (int i = 0; i < 6; i++) lst[l][i] = '0;
    end
    for (int i = 0; i < 6; i++) lst[0][i] = ax[i];
    lst[1][0] = ax[1];
    lst[1][1] = qte_pkg::scale(ax[2], 2);
    lst[1][2] = qte_pkg::scale(ax[3], 3);
    lst[1][3] = qte_pkg::scale(ax[4], 4);
    lst[1][4] = qte_pkg::scale(ax[5], 5);
    lst[2][0] = qte_pkg::scale(ax[2], 2);
    lst[2][1] = qte_pkg::scale(ax[3], 6);
    lst[2][2] = qte_pkg::scale(ax[4], 12);
    lst[2][3] = qte_pkg::scale(ax[5], 20);
    lst[3][0] = qte_pkg::scale(ax[3], 6);
    lst[3][1] = qte_pkg::scale(ax[4], 24);
    lst[3][2] = qte_pkg::scale(ax[5], 60);
  end

  // The row moves whenever the output register can take a word.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !busy && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Four lanes of Horner cells.
  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign ctl[l][0] = '{valid: in_fire, t: sample_time_i};
    assign acc[l][0] = AW'(lst[l][5]);
    for (genvar s = 0; s < NC; s++) begin : g_cell
      qte_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .ctl_i  (ctl[l][s]),
        .acc_i  (acc[l][s]),
        .coef_i (lst[l][NC-1-s]),
        .ctl_o  (ctl[l][s+1]),
        .acc_o  (acc[l][s+1])
      );
    end
    assign lane_valid[l] = ctl[l][NC].valid;
  end

  // Floor to Q16.16 and saturate each lane.
  always_comb begin
    logic signed [AW-1:0] shv;
    logic                 hi_ones, hi_zero;
    for (int l = 0; l < NL; l++) begin
      shv     = acc[l][NC] >>> qte_pkg::VAL_FRAC;
      hi_ones = &shv[AW-1:VW-1];
      hi_zero = ~|shv[AW-1:VW-1];
      lane_sat[l] = !(hi_ones || hi_zero);
      if (hi_ones || hi_zero) begin
        lane_val[l] = shv[VW-1:0];
      end else if (shv[AW-1]) begin
        lane_val[l] = {1'b1, {(VW-1){1'b0}}};
      end else begin
        lane_val[l] = {1'b0, {(VW-1){1'b1}}};
      end
    end
  end

  assign last_valid = &lane_valid;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) val_q[l] <= failed ? '0 : lane_val[l];
      if (failed)         status_q <= qte_pkg::STATUS_ZERO;
      else if (|lane_sat) status_q <= qte_pkg::STATUS_SAT;
      else                status_q <= qte_pkg::STATUS_OK;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = val_q[0];
  assign velocity_o     = val_q[1];
  assign acceleration_o = val_q[2];
  assign jerk_o         = val_q[3];
  assign status_o       = status_q;

endmodule

`default_nettype wire

// ----- tb/sv/quintic_trajectory_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator_tb
// Self-checking bench: coefficient solve and trajectory sampling are predicted
// in the bench and every output word is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quintic_trajectory_evaluator_tb;

  localparam logic [qte_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_STALL     = 400;
  localparam int DRAIN_CYCLES   = 24;

  typedef struct {
    logic signed [qte_pkg::VAL_W-1:0] pos;
    logic signed [qte_pkg::VAL_W-1:0] vel;
    logic signed [qte_pkg::VAL_W-1:0] acc;
    logic signed [qte_pkg::VAL_W-1:0] jerk;
    logic [1:0]                       status;
  } traj_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [qte_pkg::REG_IDX_W-1:0] cfg_idx = '0;
  logic [qte_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [qte_pkg::TIME_W-1:0] sample_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [qte_pkg::VAL_W-1:0] position, velocity, acceleration, jerk;
  logic [1:0] status;

  quintic_trajectory_evaluator u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_time_i  (sample_time),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .position_o     (position),
    .velocity_o     (velocity),
    .acceleration_o (acceleration),
    .jerk_o         (jerk),
    .status_o       (status)
  );

  always #10 clk = ~clk;

  // Predictor state: shadow registers and the solved coefficients.
  logic [qte_pkg::CFG_W-1:0]         shadow_regs [qte_pkg::NUM_REGS];
  logic signed [qte_pkg::COEF_W-1:0] traj_coef [6];
  bit                                duration_zero;
  logic signed [127:0]               horner_c [6];

  logic [qte_pkg::TIME_W-1:0] pending_times [$];
  traj_sample_t      expected_samples [$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatch_cnt = 0;
  bit  stall_req = 1'b0;
  bit  stall_ack = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  // Divides a boundary numerator by 2 T^k and saturates it to a coefficient.
  function automatic logic [qte_pkg::COEF_W-1:0] coef_from_numer(
      logic signed [127:0] numer, logic [qte_pkg::TIME_W-1:0] dur, int k);
    logic [127:0] mag;
    logic [127:0] cmax;
    logic [127:0] res;
    bit neg;
    neg = numer[127];
    mag = neg ? -numer : numer;
    mag = mag >> qte_pkg::PRESCALE;
    for (int j = 0; j < k; j++) begin
      mag = (mag << qte_pkg::TIME_FRAC) / {104'd0, dur};
      if (mag > (128'd1 << qte_pkg::CLAMP_BIT)) mag = 128'd1 << qte_pkg::CLAMP_BIT;
    end
    cmax = (128'd1 << (qte_pkg::COEF_W - 1)) - (neg ? 128'd0 : 128'd1);
    if (mag > cmax) mag = cmax;
    res = neg ? (~mag + 128'd1) : mag;
    return res[qte_pkg::COEF_W-1:0];
  endfunction

  // Closed-form quintic solve from the shadow registers.
  function automatic void solve_coefs();
    logic signed [127:0] p0, v0, a0, p1, v1, a1, h, dd, n1, n2, n3, numer;
    logic [qte_pkg::TIME_W-1:0] dur;
    dur = shadow_regs[qte_pkg::REG_DURATION][qte_pkg::TIME_W-1:0];
    if (dur == '0) begin
      for (int k = 0; k < 6; k++) traj_coef[k] = '0;
      duration_zero = 1'b1;
      return;
    end
    duration_zero = 1'b0;
    p0 = $signed(shadow_regs[qte_pkg::REG_START_POS]);
    v0 = $signed(shadow_regs[qte_pkg::REG_START_VEL]);
    a0 = $signed(shadow_regs[qte_pkg::REG_START_ACC]);
    p1 = $signed(shadow_regs[qte_pkg::REG_END_POS]);
    v1 = $signed(shadow_regs[qte_pkg::REG_END_VEL]);
    a1 = $signed(shadow_regs[qte_pkg::REG_END_ACC]);
    h  = p1 - p0;
    dd = $signed({104'd0, dur});
    traj_coef[0] = qte_pkg::COEF_W'(p0 <<< 16);
    traj_coef[1] = qte_pkg::COEF_W'(v0 <<< 16);
    traj_coef[2] = qte_pkg::COEF_W'(a0 <<< 15);
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin
          n1 = 20;  n2 = -(8 * v1 + 12 * v0); n3 = a1 - 3 * a0;
        end
        1: begin
          n1 = -30; n2 = 14 * v1 + 16 * v0;   n3 = 3 * a0 - 2 * a1;
        end
        default: begin
          n1 = 12;  n2 = -6 * (v1 + v0);      n3 = a1 - a0;
        end
      endcase
      numer = ((n1 * h) <<< 32) + ((n2 * dd) <<< 16) + n3 * dd * dd;
      traj_coef[k + 3] = coef_from_numer(numer, dur, k + 3);
    end
  endfunction

  // Horner evaluation of horner_c[deg..0] at t, floored to Q16.16 and saturated.
  function automatic logic [qte_pkg::VAL_W-1:0] horner_eval(int deg,
      logic [qte_pkg::TIME_W-1:0] t, inout bit sat);
    logic signed [127:0] acc;
    logic signed [127:0] tt;
    tt = $signed({104'd0, t});
    acc = horner_c[deg];
    for (int i = deg - 1; i >= 0; i--)
      acc = ((acc * tt) >>> qte_pkg::TIME_FRAC) + horner_c[i];
    acc = acc >>> (qte_pkg::COEF_FRAC - qte_pkg::VAL_FRAC);
    if (acc > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (acc < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return acc[qte_pkg::VAL_W-1:0];
  endfunction

  function automatic traj_sample_t predict_sample(logic [qte_pkg::TIME_W-1:0] t);
    traj_sample_t s;
    logic signed [127:0] a [6];
    bit sat;
    sat = 1'b0;
    if (duration_zero) begin
      s.pos = '0; s.vel = '0; s.acc = '0; s.jerk = '0;
      s.status = qte_pkg::STATUS_ZERO;
      return s;
    end
    for (int k = 0; k < 6; k++) a[k] = traj_coef[k];
    for (int k = 0; k < 6; k++) horner_c[k] = a[k];
    s.pos = horner_eval(5, t, sat);
    horner_c[0] = a[1]; horner_c[1] = 2 * a[2]; horner_c[2] = 3 * a[3];
    horner_c[3] = 4 * a[4]; horner_c[4] = 5 * a[5];
    s.vel = horner_eval(4, t, sat);
    horner_c[0] = 2 * a[2]; horner_c[1] = 6 * a[3]; horner_c[2] = 12 * a[4];
    horner_c[3] = 20 * a[5];
    s.acc = horner_eval(3, t, sat);
    horner_c[0] = 6 * a[3]; horner_c[1] = 24 * a[4]; horner_c[2] = 60 * a[5];
    s.jerk = horner_eval(2, t, sat);
    s.status = sat ? qte_pkg::STATUS_SAT : qte_pkg::STATUS_OK;
    return s;
  endfunction

  // Sender: offers queued sample times, predicts each word as it is taken.
  always @(posedge clk) begin
    bit taken;
    taken = in_valid && in_ready;
    if (rst_n) begin
      if (taken) expected_samples.push_back(predict_sample(sample_time));
      if (!in_valid || taken) begin
        if (pending_times.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          sample_time <= pending_times.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off.
  always @(posedge clk) begin
    traj_sample_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected word pos=%h vel=%h acc=%h jerk=%h status=%0d",
                   $time, position, velocity, acceleration, jerk, status);
          mismatch_cnt++;
        end else begin
          e = expected_samples.pop_front();
          if (position !== e.pos) begin
            $display("%0t: position expected %h actual %h", $time, e.pos, position);
            mismatch_cnt++;
          end
          if (velocity !== e.vel) begin
            $display("%0t: velocity expected %h actual %h", $time, e.vel, velocity);
            mismatch_cnt++;
          end
          if (acceleration !== e.acc) begin
            $display("%0t: acceleration expected %h actual %h", $time, e.acc,
                     acceleration);
            mismatch_cnt++;
          end
          if (jerk !== e.jerk) begin
            $display("%0t: jerk expected %h actual %h", $time, e.jerk, jerk);
            mismatch_cnt++;
          end
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            mismatch_cnt++;
          end
        end
      end
      if (stall_req != stall_ack) begin
        stall_ack  <= stall_req;
        stall_left <= LONG_STALL;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (expected_samples.size() > 0 || pending_times.size() > 0 || in_valid)
      @(negedge clk);
  endtask

  // One register write while idle; waits for the solve to finish.
  task automatic write_reg(logic [qte_pkg::REG_IDX_W-1:0] idx,
                           logic [qte_pkg::CFG_W-1:0] data);
    wait_drained();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx < qte_pkg::NUM_REGS) begin
      shadow_regs[idx] = (idx == qte_pkg::REG_DURATION) ?
                         {8'd0, data[qte_pkg::TIME_W-1:0]} : data;
      solve_coefs();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_all(logic [qte_pkg::CFG_W-1:0] p0, logic [qte_pkg::CFG_W-1:0] v0,
                           logic [qte_pkg::CFG_W-1:0] a0, logic [qte_pkg::CFG_W-1:0] p1,
                           logic [qte_pkg::CFG_W-1:0] v1, logic [qte_pkg::CFG_W-1:0] a1,
                           logic [qte_pkg::CFG_W-1:0] dur);
    write_reg(qte_pkg::REG_START_POS, p0);
    write_reg(qte_pkg::REG_START_VEL, v0);
    write_reg(qte_pkg::REG_START_ACC, a0);
    write_reg(qte_pkg::REG_END_POS, p1);
    write_reg(qte_pkg::REG_END_VEL, v1);
    write_reg(qte_pkg::REG_END_ACC, a1);
    write_reg(qte_pkg::REG_DURATION, dur);
  endtask

  // Signed value of moderate size, or any 32-bit value now and then.
  function automatic logic [qte_pkg::CFG_W-1:0] rand_value();
    logic [qte_pkg::CFG_W-1:0] v;
    v = $urandom;
    if ($urandom_range(9) < 7) v = qte_pkg::CFG_W'($signed(v[21:0]));
    return v;
  endfunction

  initial begin
    logic [qte_pkg::TIME_W-1:0] dur;
    for (int i = 0; i < qte_pkg::NUM_REGS; i++) shadow_regs[i] = '0;
    shadow_regs[qte_pkg::REG_DURATION] = qte_pkg::DUR_RESET;
    solve_coefs();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset coefficients, then a plain move sampled at key times.
    send_idle_pct = 19;
    recv_idle_pct = 58;
    pending_times.push_back('0);
    pending_times.push_back('1);
    write_all(32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000,
              32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    foreach (pending_times[i]) ;
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'h008000);
    pending_times.push_back(24'h010000);
    pending_times.push_back(24'h020000);
    pending_times.push_back(24'hFFFFFF);
    for (int b = 0; b < qte_pkg::TIME_W; b += 6) pending_times.push_back(24'd1 << b);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    pending_times.push_back(24'h00C000);

    // Zero duration gives zero outputs with the zero-duration status.
    write_reg(qte_pkg::REG_DURATION, 32'hFF00_0000);
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'hABCDEF);

    // Extreme boundary states over the shortest and longest durations.
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'h000001);
    pending_times.push_back(24'hFFFFFF);
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF);
    pending_times.push_back(24'h000000);
    pending_times.push_back(24'h7FFFFF);
    pending_times.push_back(24'hFFFFFF);

    // Random blocks, each with a fresh trajectory.
    for (int blk = 0; blk < 11; blk++) begin
      if (blk < 4) begin
        send_idle_pct = 19; recv_idle_pct = 58;
      end else if (blk < 8) begin
        send_idle_pct = 58; recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      dur = ($urandom_range(9) == 0) ? qte_pkg::TIME_W'($urandom) :
            qte_pkg::TIME_W'($urandom_range(32768, 262144));
      write_all(rand_value(), rand_value(), rand_value(), rand_value(),
                rand_value(), rand_value(), {8'd0, dur});
      if (blk == 2) stall_req = ~stall_req;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(9) < 8 && dur != '0)
          pending_times.push_back(qte_pkg::TIME_W'($urandom_range(0, 2 * dur)));
        else
          pending_times.push_back(qte_pkg::TIME_W'($urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qte_pkg.sv
rtl/core/qte_div.sv
rtl/core/qte_solver.sv
rtl/core/qte_cell.sv
rtl/core/quintic_trajectory_evaluator.sv
tb/sv/quintic_trajectory_evaluator_tb.sv
